/* rtl/core/x64_prologue_length_decoder_unit_macros.svh */
// Assertion macros for the x64 prologue length decoder.
// Included by the core and top-level RTL files; no other dependencies.
`ifndef X64_PROLOGUE_LENGTH_DECODER_UNIT_MACROS_SVH
`define X64_PROLOGUE_LENGTH_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define X64PLD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("x64pld: assertion failed");
`define X64PLD_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("x64pld: implication failed");
`else
`define X64PLD_ASSERT(lbl, clk, rst_n, prop)
`define X64PLD_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/x64pld_pkg.sv */
// Shared types and constants for the x64 prologue length decoder.
// No dependencies.
`default_nettype none

package x64pld_pkg;

    localparam logic [6:0] MAX_WINDOW = 7'd64;

    // legacy prefixes
    localparam logic [7:0] PFX_LOCK  = 8'hF0;
    localparam logic [7:0] PFX_REPNE = 8'hF2;
    localparam logic [7:0] PFX_REP   = 8'hF3;
    localparam logic [7:0] PFX_CS    = 8'h2E;
    localparam logic [7:0] PFX_SS    = 8'h36;
    localparam logic [7:0] PFX_DS    = 8'h3E;
    localparam logic [7:0] PFX_ES    = 8'h26;
    localparam logic [7:0] PFX_FS    = 8'h64;
    localparam logic [7:0] PFX_GS    = 8'h65;
    localparam logic [7:0] PFX_OPSZ  = 8'h66;
    localparam logic [7:0] REX_LO    = 8'h40;
    localparam logic [7:0] REX_HI    = 8'h4F;

    // opcodes
    localparam logic [7:0] OP_NOP      = 8'h90;
    localparam logic [7:0] OP_RET      = 8'hC3;
    localparam logic [7:0] OP_INT3     = 8'hCC;
    localparam logic [7:0] OP_LEAVE    = 8'hC9;
    localparam logic [7:0] OP_PUSH_LO  = 8'h50;
    localparam logic [7:0] OP_POP_HI   = 8'h5F;
    localparam logic [7:0] OP_CALL     = 8'hE8;
    localparam logic [7:0] OP_JMP      = 8'hE9;
    localparam logic [7:0] OP_JMP8     = 8'hEB;
    localparam logic [7:0] OP_LOOP_LO  = 8'hE0;
    localparam logic [7:0] OP_JRCXZ    = 8'hE3;
    localparam logic [7:0] OP_JCC_LO   = 8'h70;
    localparam logic [7:0] OP_JCC_HI   = 8'h7F;
    localparam logic [7:0] OP_ESC      = 8'h0F;
    localparam logic [7:0] OP_GRP5     = 8'hFF;
    localparam logic [7:0] OP_MOVI8_LO = 8'hB0;
    localparam logic [7:0] OP_MOVI8_HI = 8'hB7;
    localparam logic [7:0] OP_MOVI_LO  = 8'hB8;
    localparam logic [7:0] OP_MOVI_HI  = 8'hBF;
    localparam logic [7:0] OP_PUSH_I8  = 8'h6A;
    localparam logic [7:0] OP_PUSH_I32 = 8'h68;
    localparam logic [7:0] OP_MOV_RM_I = 8'hC7;
    localparam logic [7:0] OP_ALU_I32  = 8'h81;
    localparam logic [7:0] OP_ALU_I8   = 8'h83;
    localparam logic [7:0] OP_MOV_LO   = 8'h88;
    localparam logic [7:0] OP_MOV_HI   = 8'h8B;
    localparam logic [7:0] OP_LEA      = 8'h8D;

    // ModR/M / SIB fields
    localparam logic [1:0] MOD_MEM = 2'd0;
    localparam logic [1:0] MOD_D8  = 2'd1;
    localparam logic [1:0] MOD_D32 = 2'd2;
    localparam logic [1:0] MOD_REG = 2'd3;
    localparam logic [2:0] RM_SIB  = 3'd4;
    localparam logic [2:0] RM_DISP = 3'd5;

    // config register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_COVER_LEN   = 1'b0;
    localparam t_cfg_idx CFG_SCAN_WINDOW = 1'b1;

    typedef enum logic [1:0] {
        VD_FOUND  = 2'd0,
        VD_UNSAFE = 2'd1,
        VD_WINDOW = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        PH_PFX   = 3'd0,
        PH_OPC   = 3'd1,
        PH_MODRM = 3'd2,
        PH_SIB   = 3'd3,
        PH_TAIL  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [6:0] cover_len;
        logic [6:0] scan_window;
    } t_cfg;

    typedef struct packed {
        logic [6:0] len;
        t_verdict   verdict;
    } t_result;

    typedef struct packed {
        logic       active;
        logic [6:0] pos;
        t_phase     phase;
        logic       rex_w;
        logic       opsz;
        logic [1:0] modv;
        logic [3:0] pending;
    } t_dec_state;

    localparam t_dec_state DEC_RESET = '{
        active:  1'b0,
        pos:     7'd0,
        phase:   PH_PFX,
        rex_w:   1'b0,
        opsz:    1'b0,
        modv:    2'd0,
        pending: 4'd0
    };

endpackage

`default_nettype wire

/* rtl/core/x64pld_byte_if.sv */
// Input channel carrying code bytes into the prologue length decoder.
// No dependencies.
`default_nettype none

interface x64pld_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       start_scan;

    modport source(output valid, output code_byte, output start_scan, input ready);
    modport sink(input valid, input code_byte, input start_scan, output ready);
endinterface

`default_nettype wire

/* rtl/core/x64pld_result_if.sv */
// Result channel of the prologue length decoder.
// No dependencies.
`default_nettype none

interface x64pld_result_if;
    logic       valid;
    logic       ready;
    logic [6:0] prologue_length;
    logic [1:0] verdict;

    modport source(output valid, output prologue_length, output verdict, input ready);
    modport sink(input valid, input prologue_length, input verdict, output ready);
endinterface

`default_nettype wire

/* rtl/core/x64pld_decode_core.sv */
// Scan state and combinational byte decode of the prologue length decoder.
// Depends on x64pld_pkg and the assertion macro header.
`default_nettype none
`include "x64_prologue_length_decoder_unit_macros.svh"

module x64pld_decode_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_start,
    input  x64pld_pkg::t_cfg       i_cfg,
    output logic                   o_res_vld,
    output x64pld_pkg::t_result    o_res
);
    import x64pld_pkg::*;

    typedef enum logic [1:0] {
        OPK_FINISH,
        OPK_REFUSE,
        OPK_TAIL,
        OPK_MODRM
    } t_opk;

    typedef struct packed {
        t_opk       kind;
        logic [3:0] cnt;
    } t_opc;

    function automatic logic is_legacy(input logic [7:0] b);
        return b == PFX_LOCK || b == PFX_REPNE || b == PFX_REP || b == PFX_CS ||
               b == PFX_SS || b == PFX_DS || b == PFX_ES || b == PFX_FS ||
               b == PFX_GS || b == PFX_OPSZ;
    endfunction

    function automatic t_opc classify(input logic [7:0] b, input logic rex_w,
                                      input logic [3:0] imm_w);
        t_opc r;
        r.kind = OPK_REFUSE;
        r.cnt  = 4'd0;
        if (b == OP_NOP || b == OP_RET || b == OP_INT3 || b == OP_LEAVE ||
            (b >= OP_PUSH_LO && b <= OP_POP_HI)) begin
            r.kind = OPK_FINISH;
        end else if (b == OP_CALL || b == OP_JMP || b == OP_JMP8 ||
                     (b >= OP_LOOP_LO && b <= OP_JRCXZ) ||
                     (b >= OP_JCC_LO && b <= OP_JCC_HI) || b == OP_ESC || b == OP_GRP5) begin
            r.kind = OPK_REFUSE;
        end else if (b >= OP_MOVI_LO && b <= OP_MOVI_HI) begin
            r.kind = OPK_TAIL;
            r.cnt  = rex_w ? 4'd8 : imm_w;
        end else if ((b >= OP_MOVI8_LO && b <= OP_MOVI8_HI) || b == OP_PUSH_I8) begin
            r.kind = OPK_TAIL;
            r.cnt  = 4'd1;
        end else if (b == OP_PUSH_I32) begin
            r.kind = OPK_TAIL;
            r.cnt  = imm_w;
        end else if (b == OP_MOV_RM_I || b == OP_ALU_I32) begin
            r.kind = OPK_MODRM;
            r.cnt  = imm_w;
        end else if (b == OP_ALU_I8) begin
            r.kind = OPK_MODRM;
            r.cnt  = 4'd1;
        end else if ((b >= OP_MOV_LO && b <= OP_MOV_HI) || b == OP_LEA) begin
            r.kind = OPK_MODRM;
            r.cnt  = 4'd0;
        end
        return r;
    endfunction

    t_dec_state r_st;
    t_dec_state n_st;

    always_comb begin
        t_dec_state s;
        logic [6:0] win;
        logic [6:0] pos;
        logic [3:0] imm_w;
        logic [3:0] t;
        logic [3:0] p;
        logic       act_fin;
        logic       act_tail;
        logic       act_ref;
        t_opc       opc;

        o_res_vld     = 1'b0;
        o_res.len     = 7'd0;
        o_res.verdict = VD_FOUND;
        win = (i_cfg.scan_window < MAX_WINDOW) ? i_cfg.scan_window : MAX_WINDOW;
        s = r_st;
        if (i_start) begin
            s        = DEC_RESET;
            s.active = 1'b1;
        end
        n_st     = s;
        pos      = s.pos + 7'd1;
        imm_w    = (s.opsz && !s.rex_w) ? 4'd2 : 4'd4;
        t        = 4'd0;
        p        = 4'd0;
        act_fin  = 1'b0;
        act_tail = 1'b0;
        act_ref  = 1'b0;
        opc      = classify(i_byte, s.rex_w, imm_w);

        if (i_start && i_cfg.cover_len == 7'd0) begin
            o_res_vld   = 1'b1;
            n_st.active = 1'b0;
        end else if (!s.active) begin
            n_st = s;
        end else if (s.pos >= win) begin
            o_res_vld     = 1'b1;
            o_res.verdict = VD_WINDOW;
            n_st.active   = 1'b0;
        end else begin
            n_st.pos = pos;
            unique case (s.phase)
                PH_PFX, PH_OPC: begin
                    if (s.phase == PH_PFX && is_legacy(i_byte)) begin
                        if (i_byte == PFX_OPSZ) begin
                            n_st.opsz = 1'b1;
                        end
                    end else if (s.phase == PH_PFX && i_byte >= REX_LO && i_byte <= REX_HI) begin
                        n_st.rex_w = i_byte[3];
                        n_st.phase = PH_OPC;
                    end else begin
                        unique case (opc.kind)
                            OPK_FINISH: act_fin = 1'b1;
                            OPK_REFUSE: act_ref = 1'b1;
                            OPK_TAIL: begin
                                act_tail = 1'b1;
                                t        = opc.cnt;
                            end
                            OPK_MODRM: begin
                                n_st.pending = opc.cnt;
                                n_st.phase   = PH_MODRM;
                            end
                            default: act_ref = 1'b1;
                        endcase
                    end
                end
                PH_MODRM: begin
                    n_st.modv = i_byte[7:6];
                    if (i_byte[7:6] == MOD_MEM && i_byte[2:0] == RM_DISP) begin
                        act_ref = 1'b1;
                    end else if (i_byte[7:6] == MOD_REG) begin
                        act_tail = 1'b1;
                        t        = s.pending;
                    end else begin
                        p = s.pending + ((i_byte[7:6] == MOD_D8)  ? 4'd1 :
                                         (i_byte[7:6] == MOD_D32) ? 4'd4 : 4'd0);
                        if (i_byte[2:0] == RM_SIB) begin
                            n_st.pending = p;
                            n_st.phase   = PH_SIB;
                        end else begin
                            act_tail = 1'b1;
                            t        = p;
                        end
                    end
                end
                PH_SIB: begin
                    act_tail = 1'b1;
                    t = s.pending +
                        ((s.modv == MOD_MEM && i_byte[2:0] == RM_DISP) ? 4'd4 : 4'd0);
                end
                PH_TAIL: begin
                    p = (s.pending != 4'd0) ? s.pending - 4'd1 : 4'd0;
                    n_st.pending = p;
                    act_fin      = (p == 4'd0);
                end
                default: act_ref = 1'b1;
            endcase

            if (act_tail) begin
                if (t == 4'd0) begin
                    act_fin = 1'b1;
                end else if ({1'b0, pos} + {4'd0, t} > {1'b0, win}) begin
                    o_res_vld     = 1'b1;
                    o_res.verdict = VD_WINDOW;
                    n_st.active   = 1'b0;
                end else begin
                    n_st.pending = t;
                    n_st.phase   = PH_TAIL;
                end
            end

            if (act_fin) begin
                if (pos >= i_cfg.cover_len) begin
                    o_res_vld   = 1'b1;
                    o_res.len   = pos;
                    n_st.active = 1'b0;
                end else if (pos >= win) begin
                    o_res_vld     = 1'b1;
                    o_res.verdict = VD_WINDOW;
                    n_st.active   = 1'b0;
                end else begin
                    n_st.phase = PH_PFX;
                    n_st.rex_w = 1'b0;
                    n_st.opsz  = 1'b0;
                end
            end

            if (act_ref) begin
                o_res_vld     = 1'b1;
                o_res.verdict = VD_UNSAFE;
                n_st.active   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= DEC_RESET;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    `X64PLD_ASSERT(a_pos_in_window, i_clk, i_rst_n, r_st.pos <= MAX_WINDOW)
    `X64PLD_IMPLY(a_tail_pending, i_clk, i_rst_n,
        r_st.active && (r_st.phase == PH_TAIL), r_st.pending != 4'd0)
    `X64PLD_IMPLY(a_found_covers, i_clk, i_rst_n,
        o_res_vld && (o_res.verdict == VD_FOUND) && (o_res.len != 7'd0),
        o_res.len >= i_cfg.cover_len)

endmodule

`default_nettype wire

/* rtl/core/x64_prologue_length_decoder_unit.sv */
// Top level of the x64 prologue length decoder: config registers, input
// register and result register around x64pld_decode_core.
// Depends on the core, x64pld_pkg, both interfaces and the macro header.
`default_nettype none
`include "x64_prologue_length_decoder_unit_macros.svh"

// Takes one code byte per cycle and tracks the instructions of a function
// prologue, giving one result per scan: the covered length, a refusal, or
// window exhausted. An accepted byte is held in the input register and
// decoded from there; its result, if any, is registered in the result
// register. Sustained rate is one byte per cycle while the result side
// takes its beats. The rate is set by the combinational decode of one byte
// against the scan state in x64pld_decode_core. A waiting result stalls
// the input once the input register also holds a byte.
// Registers: index 0 cover_len (reset 14), index 1 scan_window (reset 64).
module x64_prologue_length_decoder_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    x64pld_byte_if.sink               i_byte,
    x64pld_result_if.source           o_result,
    input  wire logic                 i_cfg_we,
    input  wire x64pld_pkg::t_cfg_idx i_cfg_idx,
    input  wire logic [6:0]           i_cfg_data
);
    import x64pld_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_start;
    logic       r_out_vld;
    t_result    r_out;

    logic       w_adv;
    logic       w_res_vld;
    t_result    w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cover_len   <= 7'd14;
            r_cfg.scan_window <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COVER_LEN:   r_cfg.cover_len   <= i_cfg_data;
                CFG_SCAN_WINDOW: r_cfg.scan_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // decode step fires when the result register is free or draining
    assign w_adv        = r_in_vld && (!r_out_vld || o_result.ready);
    assign i_byte.ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_vld <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte  <= i_byte.code_byte;
            r_in_start <= i_byte.start_scan;
        end
    end

    x64pld_decode_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_adv),
        .i_byte    (r_in_byte),
        .i_start   (r_in_vld & r_in_start),
        .i_cfg     (r_cfg),
        .o_res_vld (w_res_vld),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_res_vld;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res_vld) begin
            r_out <= w_res;
        end
    end

    assign o_result.valid           = r_out_vld;
    assign o_result.prologue_length = r_out.len;
    assign o_result.verdict         = r_out.verdict;

    `X64PLD_IMPLY(a_no_overwrite, i_clk, i_rst_n, r_out_vld && !o_result.ready, !w_adv)
    `X64PLD_IMPLY(a_stall_cause, i_clk, i_rst_n, !i_byte.ready, r_in_vld && r_out_vld)
    `X64PLD_IMPLY(a_len_only_found, i_clk, i_rst_n,
        r_out_vld && (r_out.verdict != VD_FOUND), r_out.len == 7'd0)

endmodule

`default_nettype wire
